[design/cbms_pkg.sv]
// Shared constants, types and functions for the bus-cycle memory slave.
package cbms_pkg;

    localparam int ADDR_W    = 20;
    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 7;
    localparam int FAULT_W   = 3;
    localparam int PHASE_W   = 3;
    localparam int LOAD_OFF_W = 15;

    localparam int SEGMENT_BYTES_DEFAULT = 32768;

    localparam logic [COUNT_W-1:0] WAIT_LIMIT_RESET = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 7'd127;

    localparam logic [ADDR_W-1:0] CODE_BASE   = 20'h10000;
    localparam logic [ADDR_W-1:0] DATA_BASE   = 20'h20000;
    localparam logic [ADDR_W-1:0] VECTOR_BASE = 20'hFFFF0;

    localparam logic [DATA_W-1:0] HALT_WORD = 16'h00F4;
    localparam logic [DATA_W-1:0] MASK_WORD = 16'hFFFF;
    localparam logic [DATA_W-1:0] MASK_HIGH = 16'hFF00;
    localparam logic [DATA_W-1:0] MASK_LOW  = 16'h00FF;
    localparam logic [DATA_W-1:0] MASK_NONE = 16'h0000;

    // Reported bus phase while a lane is driven (T4).
    localparam logic [PHASE_W-1:0] BUS_PHASE_T4 = 3'd4;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE     = 3'd0,
        FAULT_ALE      = 3'd1,
        FAULT_STROBE   = 3'd2,
        FAULT_UNMAPPED = 3'd3,
        FAULT_RELEASE  = 3'd4
    } fault_t;

    // Read-only reset vector: far jump opcode in word 0, 0x0010 in word 2, zero elsewhere.
    function automatic logic [DATA_W-1:0] vector_word(input logic [2:0] idx);
        logic [DATA_W-1:0] w;
        case (idx)
            3'd0:    w = 16'h00EA;
            3'd2:    w = 16'h0010;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

[design/cbms_ifs.sv]
// Channel interfaces: bus item in, result word out, configuration write.
interface cbms_item_if;
    import cbms_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic                  ale;
    logic                  rd_n;
    logic                  wr_n;
    logic                  bhe_n;
    logic [ADDR_W-1:0]     bus_pins;
    logic [LOAD_OFF_W-1:0] load_offset;
    logic [BYTE_W-1:0]     load_byte;

    modport source (output valid, kind, ale, rd_n, wr_n, bhe_n, bus_pins, load_offset,
                    load_byte, input ready);
    modport sink (input valid, kind, ale, rd_n, wr_n, bhe_n, bus_pins, load_offset,
                  load_byte, output ready);
endinterface

interface cbms_result_if;
    import cbms_pkg::*;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  drive_data;
    logic               drive_low;
    logic               drive_high;
    logic [PHASE_W-1:0] bus_phase;
    logic [FAULT_W-1:0] fault_code;

    modport source (output valid, drive_data, drive_low, drive_high, bus_phase, fault_code,
                    input ready);
    modport sink (input valid, drive_data, drive_low, drive_high, bus_phase, fault_code,
                  output ready);
endinterface

interface cbms_cfg_if;
    import cbms_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] wait_limit;

    modport source (output valid, wait_limit, input ready);
    modport sink (input valid, wait_limit, output ready);
endinterface

[design/cpu_bus_cycle_memory_slave.sv]
// Top level: bus-cycle memory slave with code and data stores.
//
//  channel | dir | payload                                           | handshake
//  --------+-----+---------------------------------------------------+----------
//  cfg     | in  | wait_limit                                        | valid/ready
//  req     | in  | kind ale rd_n wr_n bhe_n bus_pins load_offset/byte | valid/ready
//  rsp     | out | drive_data drive_low drive_high bus_phase fault    | valid/ready
//
// One word in per clock unless rsp stalls or the clearing pass runs, one result
// word out; each word passes the store read, then the output register. The stores
// are single-port synchronous RAMs with byte writes. After reset a clearing pass
// zeroes both stores, with req held not ready; cfg writes are taken at all times.
// A stalled rsp holds the result and the stage behind it, then backs up req.ready.
module cpu_bus_cycle_memory_slave #(
    parameter int SEGMENT_BYTES = cbms_pkg::SEGMENT_BYTES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    cbms_cfg_if.sink       cfg,
    cbms_item_if.sink      req,
    cbms_result_if.source  rsp
);
    import cbms_pkg::*;

    localparam int STORE_WORDS = SEGMENT_BYTES / 2;
    localparam int WORD_AW     = $clog2(STORE_WORDS);

    typedef enum logic [1:0] {T1, T2, T3, T4} phase_t;
    typedef enum logic [1:0] {OP_KEEP, OP_CLEAR, OP_LOAD} drive_op_t;
    typedef enum logic [1:0] {SRC_CONST, SRC_CODE, SRC_DATA} drive_src_t;

    // Stores
    logic [DATA_W-1:0] code_mem [STORE_WORDS];
    logic [DATA_W-1:0] data_mem [STORE_WORDS];
    logic [DATA_W-1:0] code_rd_reg;
    logic [DATA_W-1:0] data_rd_reg;

    // Bus state
    phase_t             phase_reg, phase_next;
    logic [ADDR_W-1:0]  laddr_reg, laddr_next;
    logic               lbhe_n_reg, lbhe_n_next;
    logic               is_read_reg, is_read_next;
    logic               is_write_reg, is_write_next;
    logic [COUNT_W-1:0] ale_cnt_reg, ale_cnt_next;
    logic [COUNT_W-1:0] strobe_cnt_reg, strobe_cnt_next;
    logic [COUNT_W-1:0] release_cnt_reg, release_cnt_next;
    fault_t             fault_reg, fault_next;
    logic               drv_lo_reg, drv_lo_next;
    logic               drv_hi_reg, drv_hi_next;
    logic [COUNT_W-1:0] wait_limit_reg;

    // Clearing pass
    logic               clearing_reg;
    logic [WORD_AW-1:0] clr_idx_reg;

    // Read stage
    logic               p1_valid_reg;
    drive_op_t          p1_op_reg, op;
    drive_src_t         p1_src_reg, src;
    logic [DATA_W-1:0]  p1_mask_reg, mask_sel;
    logic [DATA_W-1:0]  p1_const_reg, const_word;

    // Output register (drive_data doubles as the held drive word)
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_lo_reg;
    logic               out_hi_reg;
    logic [PHASE_W-1:0] out_phase_reg;
    logic [FAULT_W-1:0] out_fault_reg;

    logic               accept;
    logic               p1_adv;
    logic [DATA_W-1:0]  stage_word;

    // Address decode of the latched address
    logic [ADDR_W-1:0]  code_off;
    logic [ADDR_W-1:0]  data_off;
    logic               code_hit;
    logic               data_hit;
    logic               vec_hit;
    logic [WORD_AW-1:0] code_bus_idx;
    logic [WORD_AW-1:0] data_bus_idx;
    logic [DATA_W-1:0]  lane_mask;
    logic [1:0]         lane_be;

    // Code load
    logic [ADDR_W-1:0]  load_off;
    logic               load_ok;
    logic [WORD_AW-1:0] load_idx;

    // Store access for this item
    logic [1:0]         code_we;
    logic [WORD_AW-1:0] code_wa;
    logic [DATA_W-1:0]  code_wd;
    logic [1:0]         data_we;
    logic               code_re;
    logic               data_re;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
    endfunction

    assign p1_adv    = p1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clearing_reg && (!p1_valid_reg || p1_adv);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign code_off     = laddr_reg - CODE_BASE;
    assign data_off     = laddr_reg - DATA_BASE;
    assign code_hit     = (laddr_reg >= CODE_BASE) && (code_off < ADDR_W'(SEGMENT_BYTES));
    assign data_hit     = (laddr_reg >= DATA_BASE) && (data_off < ADDR_W'(SEGMENT_BYTES));
    assign vec_hit      = laddr_reg >= VECTOR_BASE;
    assign code_bus_idx = code_off[WORD_AW:1];
    assign data_bus_idx = data_off[WORD_AW:1];

    always_comb
    begin
        if (!lbhe_n_reg)
            lane_mask = laddr_reg[0] ? MASK_HIGH : MASK_WORD;
        else
            lane_mask = laddr_reg[0] ? MASK_NONE : MASK_LOW;
    end
    assign lane_be = {|lane_mask[15:8], |lane_mask[7:0]};

    assign load_off = ADDR_W'(req.load_offset);
    assign load_ok  = load_off < ADDR_W'(SEGMENT_BYTES);
    assign load_idx = load_off[WORD_AW:1];

    always_comb
    begin
        phase_next       = phase_reg;
        laddr_next       = laddr_reg;
        lbhe_n_next      = lbhe_n_reg;
        is_read_next     = is_read_reg;
        is_write_next    = is_write_reg;
        ale_cnt_next     = ale_cnt_reg;
        strobe_cnt_next  = strobe_cnt_reg;
        release_cnt_next = release_cnt_reg;
        fault_next       = fault_reg;
        drv_lo_next      = drv_lo_reg;
        drv_hi_next      = drv_hi_reg;
        op               = OP_KEEP;
        src              = SRC_CONST;
        mask_sel         = MASK_NONE;
        const_word       = HALT_WORD;
        code_we          = 2'b00;
        code_wa          = code_bus_idx;
        code_wd          = req.bus_pins[DATA_W-1:0];
        data_we          = 2'b00;
        code_re          = 1'b0;
        data_re          = 1'b0;

        if (req.kind)
        begin
            if (load_ok)
            begin
                code_we = load_off[0] ? 2'b10 : 2'b01;
                code_wa = load_idx;
                code_wd = {req.load_byte, req.load_byte};
            end
        end
        else if (fault_reg == FAULT_NONE)
        begin
            case (phase_reg)
                T1:
                begin
                    if (req.ale)
                    begin
                        laddr_next      = req.bus_pins;
                        lbhe_n_next     = req.bhe_n;
                        phase_next      = T2;
                        strobe_cnt_next = '0;
                    end
                    else
                    begin
                        ale_cnt_next = sat_inc(ale_cnt_reg);
                        if (ale_cnt_next >= wait_limit_reg)
                            fault_next = FAULT_ALE;
                    end
                end
                T2:
                begin
                    if (!req.rd_n || !req.wr_n)
                    begin
                        // read wins when both strobes are low
                        is_read_next  = !req.rd_n;
                        is_write_next = req.rd_n;
                        phase_next    = T3;
                        if (strobe_cnt_reg != '0)
                            fault_next = FAULT_STROBE;
                    end
                    else
                    begin
                        is_read_next    = 1'b0;
                        is_write_next   = 1'b0;
                        strobe_cnt_next = sat_inc(strobe_cnt_reg);
                        if (strobe_cnt_next >= wait_limit_reg)
                            fault_next = FAULT_STROBE;
                    end
                end
                T3:
                begin
                    phase_next       = T4;
                    release_cnt_next = '0;
                    if (is_read_reg)
                    begin
                        op          = OP_LOAD;
                        mask_sel    = lane_mask;
                        drv_lo_next = lane_be[0];
                        drv_hi_next = lane_be[1];
                        if (vec_hit)
                        begin
                            src        = SRC_CONST;
                            const_word = vector_word(laddr_reg[3:1]);
                        end
                        else if (code_hit)
                        begin
                            src     = SRC_CODE;
                            code_re = 1'b1;
                        end
                        else if (data_hit)
                        begin
                            src     = SRC_DATA;
                            data_re = 1'b1;
                        end
                    end
                    else if (is_write_reg && lane_be != 2'b00)
                    begin
                        if (code_hit)
                            code_we = lane_be;
                        else if (data_hit)
                            data_we = lane_be;
                        else
                        begin
                            // unmapped write: nothing stored, phase holds
                            fault_next       = FAULT_UNMAPPED;
                            phase_next       = phase_reg;
                            release_cnt_next = release_cnt_reg;
                        end
                    end
                end
                default:
                begin
                    if ((is_read_reg && req.rd_n) || (is_write_reg && req.wr_n) ||
                        (!is_read_reg && !is_write_reg))
                    begin
                        op           = OP_CLEAR;
                        drv_lo_next  = 1'b0;
                        drv_hi_next  = 1'b0;
                        phase_next   = T1;
                        ale_cnt_next = '0;
                        if (release_cnt_reg != '0)
                            fault_next = FAULT_RELEASE;
                    end
                    else
                    begin
                        release_cnt_next = sat_inc(release_cnt_reg);
                        if (release_cnt_next >= wait_limit_reg)
                            fault_next = FAULT_RELEASE;
                    end
                end
            endcase

            // any new fault releases the bus
            if (fault_next != FAULT_NONE)
            begin
                op          = OP_CLEAR;
                drv_lo_next = 1'b0;
                drv_hi_next = 1'b0;
            end
        end
    end

    // Bus state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= T1;
            laddr_reg       <= '0;
            lbhe_n_reg      <= 1'b0;
            is_read_reg     <= 1'b0;
            is_write_reg    <= 1'b0;
            ale_cnt_reg     <= '0;
            strobe_cnt_reg  <= '0;
            release_cnt_reg <= '0;
            fault_reg       <= FAULT_NONE;
            drv_lo_reg      <= 1'b0;
            drv_hi_reg      <= 1'b0;
            wait_limit_reg  <= WAIT_LIMIT_RESET;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                wait_limit_reg <= cfg.wait_limit;
            if (accept)
            begin
                phase_reg       <= phase_next;
                laddr_reg       <= laddr_next;
                lbhe_n_reg      <= lbhe_n_next;
                is_read_reg     <= is_read_next;
                is_write_reg    <= is_write_next;
                ale_cnt_reg     <= ale_cnt_next;
                strobe_cnt_reg  <= strobe_cnt_next;
                release_cnt_reg <= release_cnt_next;
                fault_reg       <= fault_next;
                drv_lo_reg      <= drv_lo_next;
                drv_hi_reg      <= drv_hi_next;
            end
        end
    end

    // Clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == WORD_AW'(STORE_WORDS - 1))
                clearing_reg <= 1'b0;
        end
    end

    // Store ports: byte-lane writes, registered reads
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            code_mem[clr_idx_reg] <= '0;
            data_mem[clr_idx_reg] <= '0;
        end
        else if (accept)
        begin
            if (code_we[0])
                code_mem[code_wa][7:0] <= code_wd[7:0];
            if (code_we[1])
                code_mem[code_wa][15:8] <= code_wd[15:8];
            if (data_we[0])
                data_mem[data_bus_idx][7:0] <= req.bus_pins[7:0];
            if (data_we[1])
                data_mem[data_bus_idx][15:8] <= req.bus_pins[15:8];
        end
        if (accept && code_re)
            code_rd_reg <= code_mem[code_bus_idx];
        if (accept && data_re)
            data_rd_reg <= data_mem[data_bus_idx];
    end

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (accept)
            p1_valid_reg <= 1'b1;
        else if (p1_adv)
            p1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_op_reg    <= op;
            p1_src_reg   <= src;
            p1_mask_reg  <= mask_sel;
            p1_const_reg <= const_word;
        end
    end

    always_comb
    begin
        case (p1_op_reg)
            OP_CLEAR: stage_word = '0;
            OP_LOAD:
            begin
                case (p1_src_reg)
                    SRC_CODE: stage_word = code_rd_reg & p1_mask_reg;
                    SRC_DATA: stage_word = data_rd_reg & p1_mask_reg;
                    default:  stage_word = p1_const_reg & p1_mask_reg;
                endcase
            end
            default:  stage_word = out_data_reg;
        endcase
    end

    // Output register. Bus state still holds this item's values when it moves up,
    // since a newer word only lands on the same edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_lo_reg    <= 1'b0;
            out_hi_reg    <= 1'b0;
            out_phase_reg <= PHASE_W'(1);
            out_fault_reg <= FAULT_NONE;
        end
        else
        begin
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= stage_word;
                out_lo_reg    <= drv_lo_reg;
                out_hi_reg    <= drv_hi_reg;
                out_phase_reg <= PHASE_W'(phase_reg) + PHASE_W'(1);
                out_fault_reg <= fault_reg;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.drive_data = out_data_reg;
    assign rsp.drive_low  = out_lo_reg;
    assign rsp.drive_high = out_hi_reg;
    assign rsp.bus_phase  = out_phase_reg;
    assign rsp.fault_code = out_fault_reg;

endmodule

[design/cbms_checker.sv]
// Port-level checks for the bus-cycle memory slave, bound to the top level.
module cbms_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic [cbms_pkg::DATA_W-1:0]  drive_data,
    input logic                   drive_low,
    input logic                   drive_high,
    input logic [cbms_pkg::PHASE_W-1:0] bus_phase,
    input logic [cbms_pkg::FAULT_W-1:0] fault_code
);
    import cbms_pkg::*;

    // a fault never clears or changes until reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_code != FAULT_NONE) |=> (fault_code == $past(fault_code)))
        else $error("fault code changed after a fault");

    // a faulted slave has released the bus
    a_fault_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_code != FAULT_NONE) |-> (!drive_low && !drive_high && drive_data == '0))
        else $error("bus driven after a fault");

    // lanes are driven only in T4
    a_drive_in_t4: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_low || drive_high) |-> (bus_phase == BUS_PHASE_T4))
        else $error("lane driven outside T4");

    // a new result traces back to an accepted word via the read stage and output register
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a matching accepted word");

endmodule

bind cpu_bus_cycle_memory_slave cbms_checker u_cbms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .drive_data (rsp.drive_data),
    .drive_low  (rsp.drive_low),
    .drive_high (rsp.drive_high),
    .bus_phase  (rsp.bus_phase),
    .fault_code (rsp.fault_code)
);
